FILE: rtl/esc_pkg.sv
// Package for the environmental sensor compensation block.
// Holds the shared compensation constants; no dependencies.
package esc_pkg;

  localparam logic [31:0] TF_OFF_P = 32'd64000;
  localparam logic [31:0] PRESS_BASE = 32'd1048576;
  localparam logic [31:0] PRESS_MUL = 32'd3125;
  localparam logic [31:0] HUM_OFF = 32'd76800;
  localparam logic [31:0] HUM_MAX = 32'd419430400;
  localparam int unsigned DivSteps = 32;

endpackage

FILE: rtl/esc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on esc_pkg. Carries a side payload alongside each quotient.
module esc_divider
  import esc_pkg::*;
#(
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      num_i,
  input  logic [31:0]      den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [31:0]      quot_o,
  output logic [SideW-1:0] side_o
);

  logic [DivSteps:1]            vld_q;
  logic [DivSteps:1][31:0]      rem_q;
  logic [DivSteps:1][31:0]      num_q;
  logic [DivSteps:1][31:0]      den_q;
  logic [DivSteps:1][SideW-1:0] side_q;

  for (genvar s = 0; s < DivSteps; s++) begin : g_stage
    logic             vld_in;
    logic [31:0]      rem_in;
    logic [31:0]      num_in;
    logic [31:0]      den_in;
    logic [SideW-1:0] side_in;
    logic [32:0]      trial;
    logic [32:0]      shifted;
    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s];
      assign rem_in  = rem_q[s];
      assign num_in  = num_q[s];
      assign den_in  = den_q[s];
      assign side_in = side_q[s];
    end
    always_comb begin
      shifted = {rem_in, num_in[31]};
      trial   = shifted - {1'b0, den_in};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= trial[32] ? shifted[31:0] : trial[31:0];
        num_q[s+1]  <= {num_in[30:0], ~trial[32]};
        den_q[s+1]  <= den_in;
        side_q[s+1] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DivSteps];
  assign quot_o  = num_q[DivSteps];
  assign side_o  = side_q[DivSteps];

endmodule

FILE: rtl/env_sensor_compensation.sv
// Environmental sensor compensation: temperature, pressure and humidity.
// Path from accepted item to result valid: 11 arithmetic stages, 32
// divider stages and three post-divide stages. Throughput: one item
// per cycle; a stall on the output freezes the whole pipeline, set by the
// single enable that all stages share. Reset clears valid bits and the
// calibration registers to zero. Depends on esc_pkg and esc_divider.
module env_sensor_compensation
  import esc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream. tdata: raw_temperature[19:0], raw_pressure[39:20],
  // raw_humidity[55:40].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  // Output stream. tdata: temperature_centi[15:0], pressure_pa[47:16],
  // humidity_q10[64:48], zero fill to 72 bits.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Register byte addresses (8-byte spacing).
  localparam logic [5:0] AddrTemp  = 6'd0;
  localparam logic [5:0] AddrPLow  = 6'd8;
  localparam logic [5:0] AddrPMid  = 6'd16;
  localparam logic [5:0] AddrPHigh = 6'd24;
  localparam logic [5:0] AddrHum   = 6'd32;

  logic [47:0] temp_calib_q;
  logic [63:0] press_low_q, press_mid_q, hum_calib_q;
  logic [15:0] press_high_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_calib_q <= '0;
      press_low_q  <= '0;
      press_mid_q  <= '0;
      press_high_q <= '0;
      hum_calib_q  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        AddrTemp:  temp_calib_q <= pwdata[47:0];
        AddrPLow:  press_low_q  <= pwdata;
        AddrPMid:  press_mid_q  <= pwdata;
        AddrPHigh: press_high_q <= pwdata[15:0];
        AddrHum:   hum_calib_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrTemp:  prdata = {16'd0, temp_calib_q};
      AddrPLow:  prdata = press_low_q;
      AddrPMid:  prdata = press_mid_q;
      AddrPHigh: prdata = {48'd0, press_high_q};
      AddrHum:   prdata = hum_calib_q;
      default:   prdata = '0;
    endcase
  end

  // Calibration words, extended to 32 bits: T1, P1, H1 and H3 zero-extended, the rest sign-extended.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  always_comb begin
    t1 = {16'd0, temp_calib_q[15:0]};
    t2 = {{16{temp_calib_q[31]}}, temp_calib_q[31:16]};
    t3 = {{16{temp_calib_q[47]}}, temp_calib_q[47:32]};
    p1 = {16'd0, press_low_q[15:0]};
    p2 = {{16{press_low_q[31]}}, press_low_q[31:16]};
    p3 = {{16{press_low_q[47]}}, press_low_q[47:32]};
    p4 = {{16{press_low_q[63]}}, press_low_q[63:48]};
    p5 = {{16{press_mid_q[15]}}, press_mid_q[15:0]};
    p6 = {{16{press_mid_q[31]}}, press_mid_q[31:16]};
    p7 = {{16{press_mid_q[47]}}, press_mid_q[47:32]};
    p8 = {{16{press_mid_q[63]}}, press_mid_q[63:48]};
    p9 = {{16{press_high_q[15]}}, press_high_q};
    h1 = {24'd0, hum_calib_q[7:0]};
    h2 = {{16{hum_calib_q[23]}}, hum_calib_q[23:8]};
    h3 = {24'd0, hum_calib_q[31:24]};
    h4 = {{20{hum_calib_q[43]}}, hum_calib_q[43:32]};
    h5 = {{20{hum_calib_q[55]}}, hum_calib_q[55:44]};
    h6 = {{24{hum_calib_q[63]}}, hum_calib_q[63:56]};
  end

  // One enable moves the whole pipeline; it stalls only when a result
  // waits at the output and the sink is not ready.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: temperature products; raw pressure and humidity registered.
  logic        v1_q;
  logic [19:0] adcp1_q;
  logic [15:0] adch1_q;
  logic [31:0] ta1_q, tbb1_q;
  logic [31:0] ta, tb;
  always_comb begin
    ta = {15'd0, s_axis_tdata[19:3]} - {t1[30:0], 1'b0};
    tb = {16'd0, s_axis_tdata[19:4]} - t1;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ta1_q   <= ta * t2;
      tbb1_q  <= tb * tb;
      adcp1_q <= s_axis_tdata[39:20];
      adch1_q <= s_axis_tdata[55:40];
    end
  end

  // Stage 2: second temperature product.
  logic        v2_q;
  logic [19:0] adcp2_q;
  logic [15:0] adch2_q;
  logic [31:0] tv1_2_q, tsq2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tv1_2_q <= $signed(ta1_q) >>> 11;
      tsq2_q  <= 32'($signed(tbb1_q) >>> 12) * t3;
      adcp2_q <= adcp1_q;
      adch2_q <= adch1_q;
    end
  end

  // Stage 3: fine temperature.
  logic        v3_q;
  logic [19:0] adcp3_q;
  logic [15:0] adch3_q;
  logic [31:0] tf3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      tf3_q   <= tv1_2_q + 32'($signed(tsq2_q) >>> 14);
      adcp3_q <= adcp2_q;
      adch3_q <= adch2_q;
    end
  end

  // Stage 4: temperature output, pressure first products, humidity x terms.
  logic        v4_q;
  logic [19:0] adcp4_q;
  logic [15:0] adch4_q;
  logic [31:0] t4_q, pv1_4_q, psq4_q, hx4_q;
  logic [31:0] pv1, pa;
  always_comb begin
    pv1 = 32'($signed(tf3_q) >>> 1) - TF_OFF_P;
    pa  = $signed(pv1) >>> 2;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      t4_q    <= $signed(tf3_q * 32'd5 + 32'd128) >>> 8;
      pv1_4_q <= pv1;
      psq4_q  <= pa * pa;
      hx4_q   <= tf3_q - HUM_OFF;
      adcp4_q <= adcp3_q;
      adch4_q <= adch3_q;
    end
  end

  // Stage 5: temperature saturation; pressure second-level products; humidity products.
  logic        v5_q;
  logic [19:0] adcp5_q;
  logic [15:0] temp5_q;
  logic [31:0] pv2a5_q, pv1p5_5_q, pp3_5_q, pp2_5_q;
  logic [31:0] hu5_q, hx6_5_q, hx3_5_q;
  logic [15:0] tsat;
  always_comb begin
    if (t4_q[31]) tsat = (t4_q < 32'hFFFF8000) ? 16'h8000 : t4_q[15:0];
    else          tsat = (t4_q > 32'h7FFF) ? 16'h7FFF : t4_q[15:0];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      temp5_q   <= tsat;
      pv2a5_q   <= 32'($signed(psq4_q) >>> 11) * p6;
      pv1p5_5_q <= pv1_4_q * p5;
      pp3_5_q   <= p3 * 32'($signed(psq4_q) >>> 13);
      pp2_5_q   <= p2 * pv1_4_q;
      hu5_q     <= ({2'd0, adch4_q, 14'd0} - {h4[11:0], 20'd0} - h5 * hx4_q);
      hx6_5_q   <= hx4_q * h6;
      hx3_5_q   <= hx4_q * h3;
      adcp5_q   <= adcp4_q;
    end
  end

  // Stage 6: pressure sums; humidity w product.
  logic        v6_q;
  logic [19:0] adcp6_q;
  logic [15:0] temp6_q;
  logic [31:0] pv2_6_q, pv1s6_q, hu6_q, hw6_q;
  logic [31:0] pv2s, pv1s;
  always_comb begin
    pv2s = pv2a5_q + {pv1p5_5_q[30:0], 1'b0};
    pv1s = $signed(32'($signed(pp3_5_q) >>> 3) + 32'($signed(pp2_5_q) >>> 1)) >>> 18;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      pv2_6_q <= 32'($signed(pv2s) >>> 2) + {p4[15:0], 16'd0};
      pv1s6_q <= pv1s + 32'd32768;
      hu6_q   <= $signed(hu5_q + 32'd16384) >>> 15;
      hw6_q   <= 32'($signed(hx6_5_q) >>> 10) * (32'($signed(hx3_5_q) >>> 11) + 32'd32768);
      temp6_q <= temp5_q;
      adcp6_q <= adcp5_q;
    end
  end

  // Stage 7: pressure divisor and numerator base; humidity w*h2.
  logic        v7_q;
  logic [15:0] temp7_q;
  logic [31:0] pden7_q, pnb7_q, hu7_q, hw7_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pden7_q <= pv1s6_q * p1;
      pnb7_q  <= (PRESS_BASE - {12'd0, adcp6_q}) - 32'($signed(pv2_6_q) >>> 12);
      hu7_q   <= hu6_q;
      hw7_q   <= (32'($signed(hw6_q) >>> 10) + 32'd2097152) * h2;
      temp7_q <= temp6_q;
    end
  end

  // Stage 8: numerator times 3125; humidity u*w.
  logic        v8_q;
  logic [15:0] temp8_q;
  logic [31:0] pden8_q, pnum8_q, hx8_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pden8_q <= $signed(pden7_q) >>> 15;
      pnum8_q <= pnb7_q * PRESS_MUL;
      hx8_q   <= hu7_q * 32'($signed(hw7_q + 32'd8192) >>> 14);
      temp8_q <= temp7_q;
    end
  end

  // Stage 9: humidity square term.
  logic        v9_q;
  logic [15:0] temp9_q;
  logic [31:0] hx9_q, hsq9_q;
  logic [31:0] ha;
  assign ha = $signed(hx8_q) >>> 15;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hx9_q   <= hx8_q;
      hsq9_q  <= ha * ha;
      temp9_q <= temp8_q;
    end
  end

  // Stage 10: humidity correction product.
  logic        v10_q;
  logic [15:0] temp10_q;
  logic [31:0] hx10_q, hc10_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hx10_q   <= hx9_q;
      hc10_q   <= 32'($signed(hsq9_q) >>> 7) * h1;
      temp10_q <= temp9_q;
    end
  end

  // Stage 11: humidity clamp.
  logic [16:0] hum11;
  logic [31:0] hf;
  always_comb begin
    hf = hx10_q - 32'($signed(hc10_q) >>> 4);
    if (hf[31]) hf = '0;
    if (hf > HUM_MAX) hf = HUM_MAX;
    hum11 = hf[28:12];
  end

  // Valid chain over the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q} <= '0;
    end else if (en) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q} <=
        {s_axis_tvalid, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q};
    end
  end

  // The stage-8 pressure operands must align with stage 10 humidity; hold
  // them two more stages.
  logic [31:0] pnum9_q, pnum10_q, pden9_q, pden10_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pnum9_q  <= pnum8_q;
      pnum10_q <= pnum9_q;
      pden9_q  <= pden8_q;
      pden10_q <= pden9_q;
    end
  end

  // Stage 11 register: divide operands (numerator pre-scaled by two when it
  // is below 2^31, otherwise quotient doubled afterwards). The side payload
  // holds, from the top: zero divisor, large numerator, humidity, temperature.
  logic        v11_q;
  logic [31:0] dnum11_q, dden11_q;
  logic [34:0] side11_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v11_q <= 1'b0;
    else if (en) v11_q <= v10_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dnum11_q <= pnum10_q[31] ? pnum10_q : {pnum10_q[30:0], 1'b0};
      dden11_q <= pden10_q;
      side11_q <= {pden10_q == '0, pnum10_q[31], hum11, temp10_q};
    end
  end

  logic        dv;
  logic [31:0] dq;
  logic [34:0] ds;
  esc_divider #(.SideW(35)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v11_q),
    .num_i   (dnum11_q),
    .den_i   (dden11_q),
    .side_i  (side11_q),
    .valid_o (dv),
    .quot_o  (dq),
    .side_o  (ds)
  );

  // Post-divide pipeline: scale, correction products, final sum (zero when the divisor was zero).
  logic        vp1_q, vp2_q, out_v_q;
  logic [31:0] pp1_q, pw1_q, pp2_q, pc2_q;
  logic [34:0] sp1_q, sp2_q;
  logic [31:0] pq, pr;
  always_comb begin
    pq = ds[33] ? {dq[30:0], 1'b0} : dq;
    pr = pq >> 3;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp1_q   <= 1'b0;
      vp2_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vp1_q   <= dv;
      vp2_q   <= vp1_q;
      out_v_q <= vp2_q;
    end
  end
  logic [31:0] pv1_p, pv2_p;
  logic [31:0] pfin;
  always_comb begin
    pv1_p = $signed(p9 * pw1_q) >>> 12;
    pv2_p = $signed((pp1_q >> 2) * p8) >>> 13;
  end
  logic [71:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      pp1_q <= pq;
      pw1_q <= (pr * pr) >> 13;
      sp1_q <= ds;
      pp2_q <= pp1_q;
      pc2_q <= pv1_p + pv2_p + p7;
      sp2_q <= sp1_q;
      out_q <= {7'd0, sp2_q[32:16], pfin, sp2_q[15:0]};
    end
  end
  assign pfin = sp2_q[34] ? 32'd0 : pp2_q + 32'($signed(pc2_q) >>> 4);

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

FILE: tb/sv/env_sensor_compensation_tb.sv
// Self-checking testbench for env_sensor_compensation.
// Drives raw samples on the input stream, programs calibration over the APB-style
// port and checks every compensated result against a built-in predictor; needs esc_pkg.
`timescale 1ns / 1ps

module env_sensor_compensation_tb
  import esc_pkg::*;
();

  // Register indexes in the order of the register map; each sits at 8*index.
  localparam int REG_TEMP = 0;
  localparam int REG_PRESS_LOW = 1;
  localparam int REG_PRESS_MID = 2;
  localparam int REG_PRESS_HIGH = 3;
  localparam int REG_HUM = 4;
  // Drain wait: covers the block's pipeline, with a margin on top.
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [15:0] hum;
    logic [19:0] press;
    logic [19:0] temp;
  } sample_t;

  typedef struct packed {
    logic [15:0] temp_centi;
    logic [31:0] press_pa;
    logic [16:0] hum_q10;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // raw_temperature, raw_pressure, raw_humidity
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;      // temperature_centi, pressure_pa, humidity_q10
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  env_sensor_compensation dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Calibration as the predictor sees it; mirrors what has been written to the block.
  logic [47:0] cal_temp = '0;
  logic [63:0] cal_press_low = '0;
  logic [63:0] cal_press_mid = '0;
  logic [15:0] cal_press_high = '0;
  logic [63:0] cal_hum = '0;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       error_count = 0;
  int       samples_sent = 0;
  int       readings_seen = 0;
  int       pressure_zero_seen = 0;
  int       temp_saturated_seen = 0;
  int       hum_clamped_seen = 0;
  int       quiet_cycles = 0;
  bit       bus_busy = 1'b0;

  function automatic logic [31:0] sra(logic [31:0] x, int s);
    return $unsigned($signed(x) >>> s);
  endfunction

  // The datasheet's 32-bit integer compensation. All intermediates wrap at 32 bits.
  function automatic reading_t compensate(sample_t smp);
    logic [31:0] adc_t, adc_p, adc_h;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, tf, t, v1, v2, sq, p, r, x, u, w;
    reading_t res;
    adc_t = {12'd0, smp.temp};
    adc_p = {12'd0, smp.press};
    adc_h = {16'd0, smp.hum};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {16'd0, cal_press_low[15:0]};
    p2 = {{16{cal_press_low[31]}}, cal_press_low[31:16]};
    p3 = {{16{cal_press_low[47]}}, cal_press_low[47:32]};
    p4 = {{16{cal_press_low[63]}}, cal_press_low[63:48]};
    p5 = {{16{cal_press_mid[15]}}, cal_press_mid[15:0]};
    p6 = {{16{cal_press_mid[31]}}, cal_press_mid[31:16]};
    p7 = {{16{cal_press_mid[47]}}, cal_press_mid[47:32]};
    p8 = {{16{cal_press_mid[63]}}, cal_press_mid[63:48]};
    p9 = {{16{cal_press_high[15]}}, cal_press_high};
    h1 = {24'd0, cal_hum[7:0]};
    h2 = {{16{cal_hum[23]}}, cal_hum[23:8]};
    h3 = {24'd0, cal_hum[31:24]};
    h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
    h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
    h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};

    // Temperature; tf is the fine temperature shared with the other two paths.
    a = (adc_t >> 3) - (t1 << 1);
    v1 = sra(a * t2, 11);
    b = (adc_t >> 4) - t1;
    v2 = sra(sra(b * b, 12) * t3, 14);
    tf = v1 + v2;
    t = sra(tf * 32'd5 + 32'd128, 8);
    if ($signed(t) < -32768) res.temp_centi = 16'h8000;
    else if ($signed(t) > 32767) res.temp_centi = 16'h7FFF;
    else res.temp_centi = t[15:0];

    // Pressure.
    v1 = sra(tf, 1) - TF_OFF_P;
    a = sra(v1, 2);
    sq = a * a;
    v2 = sra(sq, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = sra(v2, 2) + (p4 << 16);
    v1 = sra(sra(p3 * sra(sq, 13), 3) + sra(p2 * v1, 1), 18);
    v1 = sra((32'd32768 + v1) * p1, 15);
    if (v1 == 32'd0) begin
      res.press_pa = 32'd0;
    end else begin
      p = ((PRESS_BASE - adc_p) - sra(v2, 12)) * PRESS_MUL;
      if (p < 32'h8000_0000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      r = p >> 3;
      w = (r * r) >> 13;
      v1 = sra(p9 * w, 12);
      v2 = sra((p >> 2) * p8, 13);
      p = p + sra(v1 + v2 + p7, 4);
      res.press_pa = p;
    end

    // Humidity.
    x = tf - HUM_OFF;
    u = sra(((adc_h << 14) - (h4 << 20) - (h5 * x)) + 32'd16384, 15);
    w = sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768);
    w = sra(w, 10) + 32'd2097152;
    w = sra(w * h2 + 32'd8192, 14);
    x = u * w;
    a = sra(x, 15);
    x = x - sra(sra(a * a, 7) * h1, 4);
    if (x[31]) x = 32'd0;
    if (x > HUM_MAX) x = HUM_MAX;
    res.hum_q10 = x[28:12];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Writes one calibration register: a setup phase, then an access phase.
  // The predictor's copy is updated at the same time, with bits above the width dropped.
  task automatic write_calibration(int idx, logic [63:0] value);
    bus_busy = 1'b1;
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx * 8);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TEMP:       cal_temp = value[47:0];
      REG_PRESS_LOW:  cal_press_low = value;
      REG_PRESS_MID:  cal_press_mid = value;
      REG_PRESS_HIGH: cal_press_high = value[15:0];
      REG_HUM:        cal_hum = value;
      default: ;
    endcase
    bus_busy = 1'b0;
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [63:0] pl, logic [63:0] pm,
                                  logic [15:0] ph, logic [63:0] hc);
    write_calibration(REG_TEMP, {16'd0, tc});
    write_calibration(REG_PRESS_LOW, pl);
    write_calibration(REG_PRESS_MID, pm);
    write_calibration(REG_PRESS_HIGH, {48'd0, ph});
    write_calibration(REG_HUM, hc);
  endtask

  // Half of the random samples cluster around a room-temperature reading so that
  // the realistic calibration gives sensible numbers; the rest sweep every bit.
  task automatic queue_random_samples(int count);
    sample_t smp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1, 0)) begin
        smp.temp = 20'($urandom_range(560000, 480000));
        smp.press = 20'($urandom_range(450000, 300000));
        smp.hum = 16'($urandom_range(40000, 20000));
      end else begin
        smp.temp = 20'($urandom);
        smp.press = 20'($urandom);
        smp.hum = 16'($urandom);
      end
      pending_samples.push_back(smp);
    end
  endtask

  // Lets everything in flight come out, then waits out the pipeline before a write.
  task automatic drain;
    wait (pending_samples.size() == 0 && expected_readings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps. A held item stays
  // on the bus untouched until the block takes it.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_readings.push_back(compensate(pending_samples.pop_front()));
      samples_sent++;
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left > 0 || pending_samples.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_samples[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(40, 0);
          gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end
      end
    end
  end

  // Receiver: a stall pattern of its own, with stretches of no stalling, and one
  // long hold-off once the random traffic is running so the pipeline backs up.
  int  hold_off = 0;
  bit  hold_done = 1'b0;
  int  stall_mode = 0;
  int  mode_left = 0;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
      end else begin
        reading_t want;
        want = expected_readings.pop_front();
        if (m_axis_tdata[15:0] !== want.temp_centi)
          report_mismatch("temperature_centi", {16'd0, m_axis_tdata[15:0]},
                          {16'd0, want.temp_centi});
        if (m_axis_tdata[47:16] !== want.press_pa)
          report_mismatch("pressure_pa", m_axis_tdata[47:16], want.press_pa);
        if (m_axis_tdata[64:48] !== want.hum_q10)
          report_mismatch("humidity_q10", {15'd0, m_axis_tdata[64:48]},
                          {15'd0, want.hum_q10});
        if (want.press_pa == 32'd0) pressure_zero_seen++;
        if (want.temp_centi == 16'h7FFF || want.temp_centi == 16'h8000)
          temp_saturated_seen++;
        if (want.hum_q10 == 17'd0 || want.hum_q10 == 17'd102400) hum_clamped_seen++;
      end
    end
    if (!hold_done && samples_sent >= 400) begin
      hold_done <= 1'b1;
      hold_off <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(2, 0);
        mode_left = $urandom_range(60, 5);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(3, 0) != 0);
        default: m_axis_tready <= 1'($urandom_range(1, 0));
      endcase
    end
  end

  // Watchdog: any handshake or bus write counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || bus_busy ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sample_t smp;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration is all zero, so every pressure must come out as zero.
    smp = '{hum: 16'hFFFF, press: 20'hFFFFF, temp: 20'hFFFFF};
    pending_samples.push_back(smp);
    pending_samples.push_back('0);
    drain();

    // Realistic factory calibration, directed corners of every field.
    load_calibration({16'hFC18, 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
                     {-16'sd14600, 16'd15500, -16'sd7, 16'd140},
                     16'd6000,
                     {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
    for (int k = 0; k < 3; k++) begin
      smp.temp = (k == 0) ? 20'hFFFFF : (k == 1) ? 20'd519888 : 20'd0;
      smp.press = (k == 0) ? 20'd0 : (k == 1) ? 20'd415148 : 20'hFFFFF;
      smp.hum = (k == 0) ? 16'hFFFF : (k == 1) ? 16'd30000 : 16'd0;
      pending_samples.push_back(smp);
    end
    for (int k = 0; k < 16; k++) begin
      smp.temp = 20'd519888;
      smp.press = 20'd1 << k;
      smp.hum = 16'd1 << k;
      pending_samples.push_back(smp);
    end
    queue_random_samples(150);
    drain();

    // All ones: T1, P1, H1 and H3 at their maximum, signed terms at -1.
    load_calibration('1, '1, '1, '1, '1);
    queue_random_samples(120);
    drain();

    // Most negative signed terms, unsigned terms at one.
    load_calibration({16'h8000, 16'h8000, 16'd1}, {16'h8000, 16'h8000, 16'h8000, 16'd1},
                     {4{16'h8000}}, 16'h8000,
                     {8'h80, 12'h800, 12'h800, 8'd1, 16'h8000, 8'd1});
    queue_random_samples(100);
    drain();

    // Most positive signed terms.
    load_calibration({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                     {4{16'h7FFF}}, 16'h7FFF,
                     {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
    queue_random_samples(100);
    drain();

    // Fully random calibration sets.
    for (int ph = 0; ph < 4; ph++) begin
      load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                       {$urandom, $urandom}, 16'($urandom), {$urandom, $urandom});
      queue_random_samples(100);
      drain();
    end

    $display("Sent %0d samples, checked %0d results across 9 calibration settings.",
             samples_sent, readings_seen);
    $display("Zero-pressure results: %0d, saturated temperatures: %0d, clamped humidity: %0d.",
             pressure_zero_seen, temp_saturated_seen, hum_clamped_seen);
    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/esc_pkg.sv
rtl/esc_divider.sv
rtl/env_sensor_compensation.sv
tb/sv/env_sensor_compensation_tb.sv
